// File: design/ltip_pkg.sv
// ----------------------------------------------------------------------------
// Line tracker PID package
// Shared types and register indexes for the line tracking PID unit.
// ----------------------------------------------------------------------------
package ltip_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;
    localparam int GainW = 16;
    localparam int BaseW = 7;
    localparam int DriveW = 8;

    localparam logic [CfgIdxW-1:0] CFG_BLACK_IS_LOW = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BASE_SPEED = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MS_PROP,
        MS_INTEG,
        MS_DERIV
    } t_mul_step;

endpackage

// File: design/line_track_incremental_pid_unit.sv
// ----------------------------------------------------------------------------
// Line tracking incremental PID unit
// Turns four line-sensor levels into left and right drive commands through an
// incremental PID acting on a saturating turn accumulator.
// ----------------------------------------------------------------------------
// A sensor word is taken when the block is idle. Unless the line is lost with
// the last good error within one unit, the word passes three times through one
// shared gain multiplier (proportional, integral, derivative terms), then the
// UPDATE state updates the turn accumulator and the OUT state forms the drives;
// the next word is taken only once the block is back in idle. On such a
// lost-line word the block goes straight from idle to the OUT state. A result
// waiting on the master side holds the OUT state until it is taken; a new word
// is taken while an earlier result is still waiting.
module line_track_incremental_pid_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] sensor_left_outer, [1] sensor_left_inner, [2] sensor_right_inner,
    // [3] sensor_right_outer, [7:4] zero
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] left_drive, [15:8] right_drive
    output logic [15:0] m_axis_tdata,
    // [0] line_lost_stop
    output logic [0:0]  m_axis_tuser
);
    import ltip_pkg::*;

    localparam int EW = FRAC_BITS + 4;
    localparam int DW = EW + 2;
    localparam int PW = DW + GainW + 1;
    localparam int AW = PW + 2;
    localparam int TW = FRAC_BITS + 8;
    localparam int SW = AW + 1;
    localparam int OneI = 1 << FRAC_BITS;
    localparam logic signed [EW-1:0] ONE = EW'(OneI);
    localparam logic signed [EW-1:0] THIRD = EW'(OneI / 3);
    localparam logic signed [SW-1:0] LIM = SW'(100 * OneI);
    localparam logic signed [TW-1:0] ROUND_T = TW'(OneI - 1);
    localparam logic signed [DriveW:0] DMAX = 9'sd100;

    t_state r_state, n_state;
    t_mul_step r_step;

    logic r_black_is_low;
    logic [GainW-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [BaseW-1:0] r_base_speed;

    logic signed [EW-1:0] r_err, r_e1, r_e2, r_lge;
    logic signed [TW-1:0] r_turn;
    logic signed [AW-1:0] r_acc;
    logic r_lost;

    logic r_m_valid;
    logic [15:0] r_m_data;
    logic r_m_user;

    logic [3:0] w_act;
    logic signed [4:0] w_sum;
    logic [2:0] w_cnt;
    logic signed [EW-1:0] w_err;
    logic w_no_line, w_stop;

    logic signed [DW-1:0] w_diff1, w_diff2, w_dsel;
    logic [GainW-1:0] w_gsel;
    logic signed [PW-1:0] w_prod;
    logic signed [AW-1:0] w_delta;
    logic signed [SW-1:0] w_tsum;
    logic signed [TW-1:0] w_tnext, w_tround;
    logic signed [DriveW-1:0] w_turn;
    logic signed [DriveW:0] w_left, w_right;
    logic [DriveW-1:0] w_left_c, w_right_c;
    logic w_accept, w_out_free;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Error from the active sensors.
    always_comb begin
        w_act = s_axis_tdata[3:0] ^ {4{r_black_is_low}};
        w_sum = (w_act[0] ? -5'sd3 : 5'sd0) + (w_act[1] ? -5'sd1 : 5'sd0)
              + (w_act[2] ? 5'sd1 : 5'sd0) + (w_act[3] ? 5'sd3 : 5'sd0);
        w_cnt = 3'(w_act[0]) + 3'(w_act[1]) + 3'(w_act[2]) + 3'(w_act[3]);
        w_no_line = (w_cnt == 3'd0);
        w_err = '0;
        case (w_cnt)
            3'd1: w_err = EW'(w_sum) <<< FRAC_BITS;
            3'd2: w_err = EW'(w_sum) <<< (FRAC_BITS - 1);
            3'd3: begin
                if (w_sum == 5'sd3) begin
                    w_err = ONE;
                end else if (w_sum == -5'sd3) begin
                    w_err = -ONE;
                end else if (w_sum == 5'sd1) begin
                    w_err = THIRD;
                end else begin
                    w_err = -THIRD;
                end
            end
            3'd0: begin
                if (r_lge < -ONE) begin
                    w_err = -(ONE <<< 2);
                end else begin
                    w_err = ONE <<< 2;
                end
            end
            default: w_err = '0;
        endcase
        w_stop = w_no_line && (r_lge >= -ONE) && (r_lge <= ONE);
    end

    // Shared multiplier operands.
    always_comb begin
        w_diff1 = DW'(r_err) - DW'(r_e1);
        w_diff2 = DW'(r_err) - (DW'(r_e1) <<< 1) + DW'(r_e2);
        case (r_step)
            MS_PROP: begin
                w_gsel = r_prop_gain;
                w_dsel = w_diff1;
            end
            MS_INTEG: begin
                w_gsel = r_integ_gain;
                w_dsel = DW'(r_err);
            end
            MS_DERIV: begin
                w_gsel = r_deriv_gain;
                w_dsel = w_diff2;
            end
            default: begin
                w_gsel = '0;
                w_dsel = '0;
            end
        endcase
        w_prod = $signed({1'b0, w_gsel}) * w_dsel;
    end

    // Accumulator update and drive forming.
    always_comb begin
        w_delta = r_acc >>> 8;
        w_tsum = SW'(r_turn) + SW'(w_delta);
        if (w_tsum > LIM) begin
            w_tnext = TW'(LIM);
        end else if (w_tsum < -LIM) begin
            w_tnext = TW'(-LIM);
        end else begin
            w_tnext = TW'(w_tsum);
        end
        w_tround = (r_turn < 0) ? (r_turn + ROUND_T) : r_turn;
        w_turn = DriveW'(w_tround >>> FRAC_BITS);
        w_left = $signed({2'b00, r_base_speed}) + (DriveW + 1)'(w_turn);
        w_right = $signed({2'b00, r_base_speed}) - (DriveW + 1)'(w_turn);
        if (w_left > DMAX) begin
            w_left_c = DriveW'(DMAX);
        end else if (w_left < -DMAX) begin
            w_left_c = DriveW'(-DMAX);
        end else begin
            w_left_c = DriveW'(w_left);
        end
        if (w_right > DMAX) begin
            w_right_c = DriveW'(DMAX);
        end else if (w_right < -DMAX) begin
            w_right_c = DriveW'(-DMAX);
        end else begin
            w_right_c = DriveW'(w_right);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = w_stop ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_step == MS_DERIV) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_is_low <= 1'b1;
            r_prop_gain <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_base_speed <= '0;
            r_lge <= '0;
            r_e1 <= '0;
            r_e2 <= '0;
            r_turn <= '0;
            r_step <= MS_PROP;
            r_lost <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLACK_IS_LOW: r_black_is_low <= i_cfg_wdata[0];
                    CFG_PROP_GAIN: r_prop_gain <= i_cfg_wdata;
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_wdata;
                    CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_wdata;
                    CFG_BASE_SPEED: r_base_speed <= i_cfg_wdata[BaseW-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_lost <= w_stop;
                        r_step <= MS_PROP;
                        if (!w_no_line) begin
                            r_lge <= w_err;
                        end
                    end
                end
                ST_MUL: begin
                    case (r_step)
                        MS_PROP: r_step <= MS_INTEG;
                        MS_INTEG: r_step <= MS_DERIV;
                        default: r_step <= MS_PROP;
                    endcase
                end
                ST_UPDATE: begin
                    r_e2 <= r_e1;
                    r_e1 <= r_err;
                    r_turn <= w_tnext;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_err <= w_err;
            r_acc <= '0;
        end
        if (r_state == ST_MUL) begin
            r_acc <= r_acc + AW'(w_prod);
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_m_user <= r_lost;
            r_m_data <= r_lost ? 16'd0 : {w_right_c, w_left_c};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = r_m_data;
    assign m_axis_tuser = r_m_user;

    a_turn_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_turn) <= LIM) && (SW'(r_turn) >= -LIM))
        else $error("Turn accumulator outside its limits.");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("Stop word carries non-zero drives.");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) <= 8'sd100
        && $signed(m_axis_tdata[7:0]) >= -8'sd100
        && $signed(m_axis_tdata[15:8]) <= 8'sd100
        && $signed(m_axis_tdata[15:8]) >= -8'sd100))
        else $error("Drive command outside its range.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Second word taken while busy.");

    a_state_unchanged_on_stop: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (r_state == ST_OUT && r_lost) |-> ($stable(r_turn) && $stable(r_e1)))
        else $error("State changed on a lost-line word.");

endmodule
